// ===== rtl/sixteen_bit_instruction_executor_unit_defines.svh =====
// Assertion macros for the instruction executor
`ifndef SIXTEEN_BIT_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define SIXTEEN_BIT_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SBX_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define SBX_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/sbx_pkg.sv =====
package sbx_pkg;

    localparam int DATA_BYTES        = 65536;
    localparam int VALUE_STACK_DEPTH = 256;
    localparam int FRAME_DEPTH       = 16;
    localparam int REGISTER_COUNT    = 8;

    localparam int DA_W = $clog2(DATA_BYTES);
    localparam int VS_W = $clog2(VALUE_STACK_DEPTH);
    localparam int FD_W = $clog2(FRAME_DEPTH);
    localparam int RG_W = $clog2(REGISTER_COUNT);
    localparam int FR_W = FD_W + RG_W;

    typedef enum logic [4:0] {
        CMD_HALT = 5'd0, CMD_JMP = 5'd1, CMD_CJMP = 5'd2, CMD_OJMP = 5'd3,
        CMD_CALL = 5'd4, CMD_RET = 5'd5, CMD_PUSH = 5'd6, CMD_POP = 5'd7,
        CMD_LOADB = 5'd8, CMD_LOADW = 5'd9, CMD_STOREB = 5'd10, CMD_STOREW = 5'd11,
        CMD_LOADI = 5'd12, CMD_NOP = 5'd13, CMD_ADD = 5'd14, CMD_ADDI = 5'd15,
        CMD_SUB = 5'd16, CMD_SUBI = 5'd17, CMD_MUL = 5'd18, CMD_DIV = 5'd19,
        CMD_AND = 5'd20, CMD_OR = 5'd21, CMD_XOR = 5'd22, CMD_NOTB = 5'd23,
        CMD_SAL = 5'd24, CMD_SAR = 5'd25, CMD_EQU = 5'd26, CMD_LT = 5'd27,
        CMD_LTE = 5'd28, CMD_NOTC = 5'd29, CMD_RSV0 = 5'd30, CMD_RSV1 = 5'd31
    } t_cmd;

    typedef enum logic [2:0] {
        ERR_OK = 3'd0, ERR_DIV0 = 3'd1, ERR_FOVF = 3'd2, ERR_FUNF = 3'd3,
        ERR_SOVF = 3'd4, ERR_SUNF = 3'd5
    } t_err;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_MEM1, ST_MEM2, ST_MEM3, ST_DIV, ST_DIVFIN,
        ST_CALL, ST_RET, ST_RETW, ST_DONE
    } t_state;

    typedef struct packed {
        logic [4:0]  command;
        logic [2:0]  reg_dest;
        logic [2:0]  reg_src1;
        logic [2:0]  reg_src2;
        logic [15:0] address;
        logic signed [15:0] immediate;
        logic [13:0] return_index;
    } t_in;

    typedef struct packed {
        logic [13:0] next_pc;
        logic        redirect;
        logic        halted;
        logic signed [15:0] written_value;
        logic        overflow_flag;
        logic        compare_flag;
        logic [2:0]  error_code;
    } t_out;

    typedef struct packed {
        logic        start;
        logic        sign_q;
        logic [15:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

endpackage

// ===== rtl/sbx_if.sv =====
interface sbx_in_if import sbx_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sbx_out_if import sbx_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sbx_ram.sv =====
module sbx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/sbx_div.sv =====
module sbx_div import sbx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [15:0] o_quot
);
    logic [15:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy, r_neg;
    logic [16:0] w_trial;

    assign w_trial = {r_rem[15:0], r_q[15]} - {1'b0, r_dvs};
    assign n_rem   = w_trial[16] ? {r_rem[15:0], r_q[15]} : w_trial;
    assign n_q     = {r_q[14:0], ~w_trial[16]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd16;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_busy <= 1'b0;
            end
        end
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_neg <= i_req.sign_q;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_busy && (r_cnt == 5'd1);
    assign o_quot = r_neg ? (16'd0 - n_q) : n_q;
endmodule

// ===== rtl/sixteen_bit_instruction_executor_unit.sv =====
// Channel  Dir  Payload
// i_cmd    in   command, reg_dest, reg_src1, reg_src2, address, immediate, return_index
// o_res    out  next_pc, redirect, halted, written_value, flags, error_code
// One instruction at a time. The frame store and data memory have registered
// reads; the divider produces one quotient bit per cycle. Synchronous
// active-low reset clears registers, flags, pointers; memories are not
// cleared. A stalled result holds until taken; no new transaction until then.
`include "sixteen_bit_instruction_executor_unit_defines.svh"
module sixteen_bit_instruction_executor_unit import sbx_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbx_in_if.sink    i_cmd,
    sbx_out_if.source o_res
);
    t_state r_state, n_state;
    t_in    r_in;
    t_out   r_out, n_out;
    logic [15:0] r_rf [REGISTER_COUNT];
    logic        r_ovf, r_cmp;
    logic [VS_W:0] r_sp;
    logic [FD_W:0] r_fc;
    logic [RG_W:0] r_idx;
    logic [15:0]   r_ea;
    logic [7:0]    r_lo;

    logic [15:0] w_a, w_b, w_d;
    assign w_a = r_rf[r_in.reg_src1];
    assign w_b = r_rf[r_in.reg_src2];
    assign w_d = r_rf[r_in.reg_dest];

    // memories
    logic dm_we; logic [DA_W-1:0] dm_wa, dm_ra; logic [7:0] dm_wd, dm_rd;
    logic vs_we; logic [VS_W-1:0] vs_wa, vs_ra; logic [15:0] vs_rd;
    logic fr_we; logic [FR_W-1:0] fr_wa, fr_ra; logic [15:0] fr_rd;
    logic fx_we; logic [FD_W-1:0] fx_wa, fx_ra; logic [15:0] fx_rd;

    sbx_ram #(.WIDTH(8), .DEPTH(DATA_BYTES)) u_dmem (
        .i_clk(i_clk), .i_we(dm_we), .i_waddr(dm_wa), .i_wdata(dm_wd),
        .i_raddr(dm_ra), .o_rdata(dm_rd));
    sbx_ram #(.WIDTH(16), .DEPTH(VALUE_STACK_DEPTH)) u_vstk (
        .i_clk(i_clk), .i_we(vs_we), .i_waddr(vs_wa), .i_wdata(w_d),
        .i_raddr(vs_ra), .o_rdata(vs_rd));
    sbx_ram #(.WIDTH(16), .DEPTH(FRAME_DEPTH * REGISTER_COUNT)) u_freg (
        .i_clk(i_clk), .i_we(fr_we), .i_waddr(fr_wa), .i_wdata(r_rf[r_idx[RG_W-1:0]]),
        .i_raddr(fr_ra), .o_rdata(fr_rd));
    sbx_ram #(.WIDTH(16), .DEPTH(FRAME_DEPTH)) u_fret (
        .i_clk(i_clk), .i_we(fx_we), .i_waddr(fx_wa),
        .i_wdata({r_ovf, r_cmp, r_in.return_index}),
        .i_raddr(fx_ra), .o_rdata(fx_rd));

    // divider
    t_div_req div_req;
    logic div_done; logic [15:0] div_q;
    sbx_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .o_done(div_done), .o_quot(div_q));
    assign div_req.start    = (r_state == ST_EXEC) && (t_cmd'(r_in.command) == CMD_DIV)
                              && (w_b != 16'd0);
    assign div_req.sign_q   = w_a[15] ^ w_b[15];
    assign div_req.dividend = w_a[15] ? 16'd0 - w_a : w_a;
    assign div_req.divisor  = w_b[15] ? 16'd0 - w_b : w_b;

    // shared ALU
    logic signed [16:0] w_sum;
    logic signed [31:0] w_prod;
    logic [15:0] w_rhs, w_lhs, w_res, w_ma, w_mr, w_mb;
    logic w_sub, w_ovf;
    logic [15:0] w_ea1, w_ea2;
    always_comb begin
        w_sub = (t_cmd'(r_in.command) == CMD_SUB) || (t_cmd'(r_in.command) == CMD_SUBI);
        w_lhs = ((t_cmd'(r_in.command) == CMD_ADDI) || (t_cmd'(r_in.command) == CMD_SUBI))
                ? w_d : w_a;
        w_rhs = ((t_cmd'(r_in.command) == CMD_ADDI) || (t_cmd'(r_in.command) == CMD_SUBI))
                ? r_in.immediate : w_b;
        w_sum = w_sub ? ($signed({w_lhs[15], w_lhs}) - $signed({w_rhs[15], w_rhs}))
                      : ($signed({w_lhs[15], w_lhs}) + $signed({w_rhs[15], w_rhs}));
        w_prod = $signed(w_a) * $signed(w_b);
        w_ma = w_a[15] ? 16'd0 - w_a : w_a;
        w_mb = w_b[15] ? 16'd0 - w_b : w_b;
        w_mr = w_prod[15] ? 16'd0 - w_prod[15:0] : w_prod[15:0];
        w_res = '0;
        w_ovf = r_ovf;
        unique case (t_cmd'(r_in.command))
            CMD_ADD, CMD_ADDI, CMD_SUB, CMD_SUBI: begin
                w_res = w_sum[15:0];
                w_ovf = w_sum[16] ^ w_sum[15];
            end
            CMD_MUL: begin
                w_res = w_prod[15:0];
                w_ovf = ({1'b0, w_mb} > 17'd1) && ({1'b0, w_mr} < {1'b0, w_ma});
            end
            CMD_AND:  w_res = w_a & w_b;
            CMD_OR:   w_res = w_a | w_b;
            CMD_XOR:  w_res = w_a ^ w_b;
            CMD_NOTB: w_res = ~w_a;
            CMD_SAL:  w_res = (w_b >= 16'd16) ? 16'd0 : (w_a << w_b[3:0]);
            CMD_SAR:  w_res = (w_b >= 16'd16) ? {16{w_a[15]}}
                              : 16'($signed(w_a) >>> w_b[3:0]);
            CMD_LOADI: w_res = r_in.immediate;
            default: ;
        endcase
        w_ea1 = r_in.address + r_rf[7];
        w_ea2 = r_in.address + {r_rf[7][14:0], 1'b0};
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_out = r_out;
        dm_we = 1'b0; dm_wa = '0; dm_ra = '0; dm_wd = '0;
        vs_we = 1'b0; vs_wa = r_sp[VS_W-1:0]; vs_ra = '0;
        fr_we = 1'b0; fr_wa = {r_fc[FD_W-1:0], r_idx[RG_W-1:0]};
        fr_ra = {r_fc[FD_W-1:0] - FD_W'(1), r_idx[RG_W-1:0]};
        fx_we = 1'b0; fx_wa = r_fc[FD_W-1:0]; fx_ra = r_fc[FD_W-1:0] - FD_W'(1);
        unique case (r_state)
            ST_IDLE: if (i_cmd.valid) n_state = ST_EXEC;
            ST_EXEC: begin
                n_out = '0;
                n_out.next_pc = r_in.return_index;
                n_out.overflow_flag = r_ovf;
                n_out.compare_flag = r_cmp;
                n_out.error_code = ERR_OK;
                n_state = ST_DONE;
                unique case (t_cmd'(r_in.command))
                    CMD_HALT: n_out.halted = 1'b1;
                    CMD_JMP: begin
                        n_out.next_pc = r_in.address[15:2]; n_out.redirect = 1'b1;
                    end
                    CMD_CJMP: if (r_cmp) begin
                        n_out.next_pc = r_in.address[15:2]; n_out.redirect = 1'b1;
                    end
                    CMD_OJMP: if (r_ovf) begin
                        n_out.next_pc = r_in.address[15:2]; n_out.redirect = 1'b1;
                    end
                    CMD_CALL: if (r_fc >= (FD_W+1)'(FRAME_DEPTH)) begin
                        n_out.error_code = ERR_FOVF;
                    end else begin
                        n_out.next_pc = r_in.address[15:2]; n_out.redirect = 1'b1;
                        n_state = ST_CALL;
                    end
                    CMD_RET: if (r_fc == '0) begin
                        n_out.error_code = ERR_FUNF;
                    end else begin
                        n_out.redirect = 1'b1;
                        n_state = ST_RET;
                    end
                    CMD_PUSH: if (r_sp >= (VS_W+1)'(VALUE_STACK_DEPTH)) begin
                        n_out.error_code = ERR_SOVF;
                    end else begin
                        vs_we = 1'b1;
                    end
                    CMD_POP: if (r_sp == '0) begin
                        n_out.error_code = ERR_SUNF;
                    end else begin
                        vs_ra = r_sp[VS_W-1:0] - VS_W'(1);
                        n_state = ST_MEM1;
                    end
                    CMD_LOADB: begin
                        dm_ra = DA_W'(w_ea1); n_state = ST_MEM1;
                    end
                    CMD_LOADW: begin
                        dm_ra = DA_W'(w_ea2); n_state = ST_MEM2;
                    end
                    CMD_STOREB: begin
                        dm_we = 1'b1; dm_wa = DA_W'(w_ea1); dm_wd = w_d[7:0];
                    end
                    CMD_STOREW: begin
                        dm_we = 1'b1; dm_wa = DA_W'(w_ea2); dm_wd = w_d[7:0];
                        n_state = ST_MEM3;
                    end
                    CMD_DIV: if (w_b == 16'd0) begin
                        n_out.error_code = ERR_DIV0;
                    end else begin
                        n_state = ST_DIV;
                    end
                    CMD_EQU: n_out.compare_flag = (w_d == w_a);
                    CMD_LT:  n_out.compare_flag = ($signed(w_d) < $signed(w_a));
                    CMD_LTE: n_out.compare_flag = ($signed(w_d) <= $signed(w_a));
                    CMD_NOTC: n_out.compare_flag = ~r_cmp;
                    CMD_NOP, CMD_RSV0, CMD_RSV1: ;
                    default: begin
                        n_out.written_value = w_res;
                        n_out.overflow_flag = w_ovf;
                    end
                endcase
            end
            ST_MEM1: begin
                n_out.written_value = (t_cmd'(r_in.command) == CMD_POP) ? vs_rd
                                      : {{8{dm_rd[7]}}, dm_rd};
                n_state = ST_DONE;
            end
            ST_MEM2: begin
                dm_ra = DA_W'(r_ea + 16'd1);
                n_state = ST_MEM2;
                if (r_idx != '0) begin
                    n_out.written_value = {dm_rd, r_lo};
                    n_state = ST_DONE;
                end
            end
            ST_MEM3: begin
                dm_we = 1'b1; dm_wa = DA_W'(r_ea + 16'd1); dm_wd = w_d[15:8];
                n_state = ST_DONE;
            end
            ST_DIV: if (div_done) begin
                n_out.written_value = div_q;
                n_state = ST_DONE;
            end
            ST_CALL: begin
                fr_we = 1'b1;
                if (r_idx == (RG_W+1)'(REGISTER_COUNT - 1)) begin
                    fx_we = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_RET: n_state = ST_RETW;
            ST_RETW: begin
                if (r_idx == (RG_W+1)'(REGISTER_COUNT)) begin
                    n_out.next_pc = fx_rd[13:0];
                    n_out.overflow_flag = fx_rd[15];
                    n_out.compare_flag = fx_rd[14];
                    n_state = ST_DONE;
                end
            end
            ST_DONE: if (o_res.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        if (r_state == ST_RET || r_state == ST_RETW) begin
            fr_ra = {r_fc[FD_W-1:0] - FD_W'(1), r_idx[RG_W-1:0]};
        end
    end

    logic [RG_W:0] r_widx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovf <= 1'b0; r_cmp <= 1'b0;
            r_sp <= '0; r_fc <= '0;
            for (int k = 0; k < REGISTER_COUNT; k++) r_rf[k] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && i_cmd.valid) r_in <= i_cmd.data;
            r_out <= n_out;
            if (r_state == ST_EXEC) begin
                r_idx <= '0;
                r_ea <= w_ea2;
                r_ovf <= n_out.overflow_flag;
                r_cmp <= n_out.compare_flag;
                if (n_state == ST_DONE && n_out.error_code == ERR_OK &&
                    !(t_cmd'(r_in.command) inside {CMD_HALT, CMD_JMP, CMD_CJMP, CMD_OJMP,
                      CMD_PUSH, CMD_STOREB, CMD_EQU, CMD_LT, CMD_LTE, CMD_NOTC, CMD_NOP,
                      CMD_RSV0, CMD_RSV1})) begin
                    r_rf[r_in.reg_dest] <= n_out.written_value;
                end
                if (t_cmd'(r_in.command) == CMD_PUSH && n_out.error_code == ERR_OK)
                    r_sp <= r_sp + (VS_W+1)'(1);
                if (t_cmd'(r_in.command) == CMD_POP && n_out.error_code == ERR_OK)
                    r_sp <= r_sp - (VS_W+1)'(1);
            end
            if (r_state == ST_MEM2) begin
                r_lo <= dm_rd;
                r_idx <= r_idx + (RG_W+1)'(1);
            end
            if (r_state == ST_MEM1 || (r_state == ST_MEM2 && r_idx != '0) ||
                (r_state == ST_DIV && div_done))
                r_rf[r_in.reg_dest] <= n_out.written_value;
            if (r_state == ST_CALL) begin
                r_idx <= r_idx + (RG_W+1)'(1);
                if (n_state == ST_DONE) r_fc <= r_fc + (FD_W+1)'(1);
            end
            if (r_state == ST_RET) begin
                r_idx <= r_idx + (RG_W+1)'(1);
                r_widx <= '0;
            end
            if (r_state == ST_RETW) begin
                if (r_idx != (RG_W+1)'(REGISTER_COUNT)) r_idx <= r_idx + (RG_W+1)'(1);
                r_rf[r_widx[RG_W-1:0]] <= fr_rd;
                r_widx <= r_widx + (RG_W+1)'(1);
                if (n_state == ST_DONE) begin
                    r_fc <= r_fc - (FD_W+1)'(1);
                    r_ovf <= fx_rd[15];
                    r_cmp <= fx_rd[14];
                end
            end
        end
    end

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign o_res.valid = (r_state == ST_DONE);
    assign o_res.data  = r_out;

    `SBX_ASSERT_IMP(a_one_side, i_clk, i_rst_n, o_res.valid, !i_cmd.ready,
        "input ready while result pending")
    `SBX_ASSERT_IMP(a_fc_range, i_clk, i_rst_n, 1'b1, r_fc <= (FD_W+1)'(FRAME_DEPTH),
        "frame count beyond depth")
    `SBX_ASSERT_IMP(a_sp_range, i_clk, i_rst_n, 1'b1, r_sp <= (VS_W+1)'(VALUE_STACK_DEPTH),
        "stack pointer beyond depth")
    `SBX_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready,
        o_res.valid && $stable(o_res.data), "stalled result changed")
endmodule
